// File: rtl/core/aac_pkg.sv
// Package for the AIMD admission controller core.
// Holds constants, function codes, state enum and payload structs; no dependencies.
`default_nettype none
package aac_pkg;
  localparam int NumAgents    = 32;
  localparam int NumCrossings = 16;
  localparam int AgentW       = 5;
  localparam int CrossW       = 4;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 12;

  typedef enum logic [2:0] {
    FUNC_REQUEST = 3'd0,
    FUNC_OBSERVE = 3'd1,
    FUNC_ACK     = 3'd2,
    FUNC_QUERY   = 3'd3,
    FUNC_END     = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN   = 2'd0,
    CFG_FACTOR = 2'd1,
    CFG_INIT   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK_RD,
    ST_OUT,
    ST_REV_RD,
    ST_REV_WR,
    ST_WIN_RD,
    ST_WIN_MUL,
    ST_WIN_WR,
    ST_SCAN,
    ST_PICK,
    ST_LIST_RD,
    ST_LIST_OUT,
    ST_CLR
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  agent_id;
    logic [3:0]  crossing_id;
    logic [15:0] wait_age;
    logic [7:0]  obs_capacity;
    logic [7:0]  obs_occupied;
    logic        obs_stalled;
    logic        obs_delayed;
    logic        obs_info_congested;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [4:0] out_agent;
    logic [3:0] out_crossing;
    logic       out_granted;
    logic       out_last;
  } out_item_t;
endpackage
`default_nettype wire

// File: rtl/core/aimd_admission_controller_core.sv
// AIMD admission controller: per-crossing windows with round-based admission.
// Request and observe pass through ST_ACK_RD; acknowledge and query pass through ST_ACK_RD
// and ST_OUT, which waits while the output register is full, and present their registered
// result while the next transaction is taken. End of round: grant checks per agent, then per
// crossing a window update and one agent scan per new grant, then a list entry per agent.
// Reset clears valid bits, observations and counters and sets windows to 256; the memories are not cleared.
`default_nettype none
module aimd_admission_controller_core import aac_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  // Request memory: crossing and age; valid bits in flip-flops.
  logic [19:0] req_mem [NumAgents];
  logic [19:0] req_rd_q;
  logic [NumAgents-1:0] req_v_q, req_v_d;
  // Grant memory: crossing per agent; valid bits in flip-flops.
  logic [CrossW-1:0] grant_mem [NumAgents];
  logic [CrossW-1:0] grant_rd_q;
  logic [NumAgents-1:0] grant_v_q, grant_v_d;
  // Per crossing state.
  logic [15:0] win_q [NumCrossings];
  logic [18:0] obs_q [NumCrossings];
  logic [5:0]  ack_q [NumCrossings];
  logic [5:0]  outs_q [NumCrossings];

  logic [11:0] gain_q;
  logic [8:0]  factor_q;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  logic [AgentW:0] ai_q, ai_d;
  logic [CrossW:0] ci_q, ci_d;
  logic [AgentW-1:0] best_q, best_d;
  logic [15:0] best_age_q, best_age_d;
  logic found_q, found_d;
  logic [24:0] prod_q, prod_d;
  logic [17:0] sum_q, sum_d;
  logic cong_q, cong_d;
  logic out_v_q, out_v_d;
  out_item_t out_q, out_d;

  logic req_we, grant_we;
  logic [AgentW-1:0] req_addr, grant_addr;
  logic [CrossW-1:0] grant_wdata;
  logic win_we, ack_inc, ack_clr_all, outs_inc, outs_clr_all, obs_we;
  logic [CrossW-1:0] cnt_idx;
  logic [15:0] win_wdata;
  logic [CrossW-1:0] c_idx;
  logic [AgentW-1:0] a_idx;
  logic in_acc;
  logic hit;
  logic [8:0] cap9;
  logic [7:0] limit;
  logic [15:0] w_cur;
  logic [18:0] ob;

  assign c_idx = ci_q[CrossW-1:0];
  assign a_idx = ai_q[AgentW-1:0];
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
  assign w_cur = win_q[c_idx];
  assign ob = obs_q[c_idx];
  assign cap9 = (ob[18:11] == 8'd0) ? 9'd1 : {1'b0, ob[18:11]};
  assign limit = (w_cur[15:8] == 8'd0) ? 8'd1 : w_cur[15:8];

  always_ff @(posedge clk_i) begin
    if (req_we) req_mem[req_addr] <= {item_q.crossing_id, item_q.wait_age};
    req_rd_q <= req_mem[req_addr];
    if (grant_we) grant_mem[grant_addr] <= grant_wdata;
    grant_rd_q <= grant_mem[grant_addr];
  end

  always_comb begin
    state_d = state_q; item_d = item_q; ai_d = ai_q; ci_d = ci_q;
    best_d = best_q; best_age_d = best_age_q; found_d = found_q;
    prod_d = prod_q; sum_d = sum_q; cong_d = cong_q;
    out_v_d = out_v_q; out_d = out_q;
    req_v_d = req_v_q; grant_v_d = grant_v_q;
    req_we = 1'b0; req_addr = a_idx;
    grant_we = 1'b0; grant_addr = a_idx; grant_wdata = c_idx;
    win_we = 1'b0; win_wdata = w_cur; ack_inc = 1'b0; ack_clr_all = 1'b0;
    outs_inc = 1'b0; outs_clr_all = 1'b0; obs_we = 1'b0;
    cnt_idx = c_idx;
    hit = 1'b0;
    if (out_v_q && !out_stall_i) out_v_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          item_d = in_data_i;
          unique case (in_data_i.func)
            FUNC_REQUEST, FUNC_OBSERVE: state_d = ST_ACK_RD;
            FUNC_ACK, FUNC_QUERY: state_d = ST_ACK_RD;
            FUNC_END: begin
              state_d = ST_REV_RD; ai_d = '0; outs_clr_all = 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
          ai_d = (in_data_i.func == FUNC_END) ? '0 : {1'b0, in_data_i.agent_id};
        end
      end
      ST_ACK_RD: begin
        grant_addr = item_q.agent_id;
        req_addr = item_q.agent_id;
        unique case (item_q.func)
          FUNC_REQUEST: begin
            req_we = 1'b1; req_v_d[item_q.agent_id] = 1'b1; state_d = ST_IDLE;
          end
          FUNC_OBSERVE: begin
            obs_we = 1'b1; state_d = ST_IDLE;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        if (!out_v_d) begin
          hit = grant_v_q[item_q.agent_id] && (grant_rd_q == item_q.crossing_id);
          out_v_d = 1'b1;
          out_d.out_kind = (item_q.func == FUNC_ACK) ? KIND_ACK : KIND_QUERY;
          out_d.out_agent = item_q.agent_id;
          out_d.out_crossing = item_q.crossing_id;
          out_d.out_granted = hit;
          out_d.out_last = 1'b1;
          if (hit && item_q.func == FUNC_ACK) begin
            grant_v_d[item_q.agent_id] = 1'b0;
            cnt_idx = item_q.crossing_id;
            ack_inc = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_REV_RD: state_d = ST_REV_WR;
      ST_REV_WR: begin
        if (grant_v_q[a_idx]) begin
          if (!req_v_q[a_idx] || req_rd_q[19:16] != grant_rd_q) begin
            grant_v_d[a_idx] = 1'b0;
          end else begin
            cnt_idx = grant_rd_q; outs_inc = 1'b1;
          end
        end
        if (ai_q == 6'(NumAgents - 1)) begin
          state_d = ST_WIN_RD; ci_d = '0;
        end else begin
          ai_d = ai_q + 6'd1; state_d = ST_REV_RD;
        end
      end
      ST_WIN_RD: begin
        cong_d = (ob[0] && !ob[1]) || ({1'b0, ob[10:3]} >= cap9) || ob[2];
        prod_d = 25'(w_cur) * 25'(factor_q);
        sum_d = 18'(gain_q) * 18'(ack_q[c_idx]);
        state_d = ST_WIN_MUL;
      end
      ST_WIN_MUL: begin
        win_we = 1'b1;
        if (cong_q) begin
          if (prod_q[24:8] > 17'hFFFF) win_wdata = 16'hFFFF;
          else if (prod_q[24:8] < 17'd256) win_wdata = 16'd256;
          else win_wdata = prod_q[23:8];
          sum_d = '0;
        end else if (ack_q[c_idx] != 6'd0) begin
          if (19'(w_cur) + 19'(sum_q) > 19'({cap9, 8'd0})) win_wdata = {cap9[7:0], 8'd0};
          else win_wdata = 16'(w_cur + sum_q);
        end else win_we = 1'b0;
        state_d = ST_WIN_WR;
      end
      ST_WIN_WR: begin
        ai_d = '0; found_d = 1'b0; best_d = '0; best_age_d = '0;
        state_d = ({2'b0, outs_q[c_idx]} < limit) ? ST_SCAN : ST_CLR;
        req_addr = '0;
      end
      ST_SCAN: begin
        // The entry at ai_q is read again so that it is ready in ST_PICK.
        req_addr = a_idx;
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (req_v_q[a_idx] && req_rd_q[19:16] == c_idx && !grant_v_q[a_idx] &&
            (!found_q || req_rd_q[15:0] > best_age_q)) begin
          found_d = 1'b1; best_d = a_idx; best_age_d = req_rd_q[15:0];
        end
        req_addr = 5'(ai_q + 6'd1);
        if (ai_q == 6'(NumAgents - 1)) begin
          ai_d = '0;
          if (found_d) begin
            grant_v_d[best_d] = 1'b1; grant_we = 1'b1;
            grant_addr = best_d; grant_wdata = c_idx; outs_inc = 1'b1;
            state_d = ST_WIN_WR;
          end else state_d = ST_CLR;
        end else begin
          ai_d = ai_q + 6'd1; state_d = ST_SCAN;
        end
      end
      ST_CLR: begin
        if (ci_q == 5'(NumCrossings - 1)) begin
          ack_clr_all = 1'b1; req_v_d = '0; ai_d = '0; state_d = ST_LIST_RD;
        end else begin
          ci_d = ci_q + 5'd1; state_d = ST_WIN_RD;
        end
      end
      ST_LIST_RD: if (!out_v_d) state_d = ST_LIST_OUT;
      ST_LIST_OUT: begin
        out_v_d = 1'b1;
        out_d.out_kind = KIND_LIST;
        out_d.out_agent = a_idx;
        out_d.out_crossing = grant_v_q[a_idx] ? grant_rd_q : '0;
        out_d.out_granted = grant_v_q[a_idx];
        out_d.out_last = (ai_q == 6'(NumAgents - 1));
        if (ai_q == 6'(NumAgents - 1)) state_d = ST_IDLE;
        else begin
          ai_d = ai_q + 6'd1; state_d = ST_LIST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_v_q <= 1'b0;
      req_v_q <= '0; grant_v_q <= '0;
      gain_q <= 12'd256; factor_q <= 9'd128;
      ai_q <= '0; ci_q <= '0; found_q <= 1'b0;
      for (int i = 0; i < NumCrossings; i++) begin
        win_q[i] <= 16'd256; obs_q[i] <= '0; ack_q[i] <= '0; outs_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; out_v_q <= out_v_d;
      req_v_q <= req_v_d; grant_v_q <= grant_v_d;
      ai_q <= ai_d; ci_q <= ci_d; found_q <= found_d;
      if (obs_we)
        obs_q[item_q.crossing_id] <= {item_q.obs_capacity, item_q.obs_occupied,
                                      item_q.obs_info_congested, item_q.obs_delayed,
                                      item_q.obs_stalled};
      if (win_we) win_q[c_idx] <= win_wdata;
      if (outs_clr_all) for (int i = 0; i < NumCrossings; i++) outs_q[i] <= '0;
      else if (outs_inc) outs_q[cnt_idx] <= outs_q[cnt_idx] + 6'd1;
      if (ack_clr_all) for (int i = 0; i < NumCrossings; i++) ack_q[i] <= '0;
      else if (ack_inc && ack_q[cnt_idx] != 6'd63)
        ack_q[cnt_idx] <= ack_q[cnt_idx] + 6'd1;
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_GAIN: gain_q <= cfg_data_i;
          CFG_FACTOR: factor_q <= cfg_data_i[8:0];
          CFG_INIT: begin
            for (int i = 0; i < NumCrossings; i++)
              win_q[i] <= {(cfg_data_i[7:0] == 8'd0) ? 8'd1 : cfg_data_i[7:0], 8'd0};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; best_q <= best_d; best_age_q <= best_age_d;
    prod_q <= prod_d; sum_q <= sum_d; cong_q <= cong_d; out_q <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q && $stable(out_q))
    else $error("result dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o)
    else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLR && ci_q == 5'(NumCrossings - 1) |=> req_v_q == '0)
    else $error("requests not cleared at round end");
endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Testbench for the AIMD admission controller core: random and directed transactions,
// a behavioral predictor of grants and windows, and an in-order result checker.
// Depends on aac_pkg and aimd_admission_controller_core.
`default_nettype none
module tb_top;
  import aac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_NONE;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  aimd_admission_controller_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [11:0] gain_q;
  logic [8:0]  factor_q;
  logic [7:0]  init_q;
  logic        grant_vld [NumAgents];
  logic [3:0]  grant_cr [NumAgents];
  logic        req_vld [NumAgents];
  logic [3:0]  req_cr [NumAgents];
  logic [15:0] req_age [NumAgents];
  logic [7:0]  obs_cap [NumCrossings];
  logic [7:0]  obs_occ [NumCrossings];
  logic [2:0]  obs_flg [NumCrossings];
  logic [15:0] win_q [NumCrossings];
  logic [5:0]  acks_q [NumCrossings];
  int          held_q [NumCrossings];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int cycle_cnt = 0;
  bit hold_off = 0;

  function automatic void add_item(in_item_t t);
    pending_items.insert(pending_items.size(), t);
  endfunction

  function automatic void add_result(out_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void reload_windows();
    for (int c = 0; c < NumCrossings; c++) win_q[c] = {(init_q == 0) ? 8'd1 : init_q, 8'd0};
  endfunction

  function automatic void predict_reset();
    gain_q = 12'd256; factor_q = 9'd128; init_q = 8'd1;
    for (int a = 0; a < NumAgents; a++) begin
      grant_vld[a] = '0; grant_cr[a] = '0; req_vld[a] = '0; req_cr[a] = '0; req_age[a] = '0;
    end
    for (int c = 0; c < NumCrossings; c++) begin
      obs_cap[c] = '0; obs_occ[c] = '0; obs_flg[c] = '0; acks_q[c] = '0; held_q[c] = 0;
    end
    reload_windows();
  endfunction

  function automatic void close_round();
    int cap, lim, best;
    logic [31:0] w, p;
    bit cong, found;
    for (int c = 0; c < NumCrossings; c++) held_q[c] = 0;
    for (int a = 0; a < NumAgents; a++) begin
      if (grant_vld[a]) begin
        if (!req_vld[a] || req_cr[a] != grant_cr[a]) grant_vld[a] = 1'b0;
        else held_q[grant_cr[a]]++;
      end
    end
    for (int c = 0; c < NumCrossings; c++) begin
      cap = (obs_cap[c] == 0) ? 1 : int'(obs_cap[c]);
      cong = (obs_flg[c][0] && !obs_flg[c][1]) || obs_occ[c] >= cap || obs_flg[c][2];
      w = 32'(win_q[c]);
      if (cong) begin
        p = (w * factor_q) >> 8;
        if (p > 32'hFFFF) p = 32'hFFFF;
        if (p < 256) p = 256;
        w = p;
      end else if (acks_q[c] > 0) begin
        p = w + gain_q * acks_q[c];
        if (p > (cap << 8)) p = cap << 8;
        w = p;
      end
      win_q[c] = w[15:0];
      lim = w >> 8;
      if (lim < 1) lim = 1;
      while (held_q[c] < lim) begin
        found = 1'b0; best = 0;
        for (int a = 0; a < NumAgents; a++) begin
          if (req_vld[a] && req_cr[a] == c && !grant_vld[a])
            if (!found || req_age[a] > req_age[best]) begin
              best = a; found = 1'b1;
            end
        end
        if (!found) break;
        grant_vld[best] = 1'b1; grant_cr[best] = c[3:0]; held_q[c]++;
      end
    end
    for (int c = 0; c < NumCrossings; c++) acks_q[c] = '0;
    for (int a = 0; a < NumAgents; a++) req_vld[a] = 1'b0;
  endfunction

  function automatic void predict_item(in_item_t t);
    out_item_t r;
    bit ok;
    int ag, cr;
    ag = int'(t.agent_id); cr = int'(t.crossing_id);
    r = '0;
    case (t.func)
      FUNC_REQUEST: begin
        req_vld[ag] = 1'b1; req_cr[ag] = t.crossing_id; req_age[ag] = t.wait_age;
      end
      FUNC_OBSERVE: begin
        obs_cap[cr] = t.obs_capacity; obs_occ[cr] = t.obs_occupied;
        obs_flg[cr] = {t.obs_info_congested, t.obs_delayed, t.obs_stalled};
      end
      FUNC_ACK, FUNC_QUERY: begin
        ok = grant_vld[ag] && grant_cr[ag] == t.crossing_id;
        if (t.func == FUNC_ACK && ok) begin
          if (acks_q[cr] < 63) acks_q[cr]++;
          grant_vld[ag] = 1'b0;
        end
        r.out_kind = (t.func == FUNC_ACK) ? KIND_ACK : KIND_QUERY;
        r.out_agent = t.agent_id; r.out_crossing = t.crossing_id;
        r.out_granted = ok; r.out_last = 1'b1;
        add_result(r);
      end
      FUNC_END: begin
        close_round();
        for (int a = 0; a < NumAgents; a++) begin
          r.out_kind = KIND_LIST; r.out_agent = a[4:0];
          r.out_crossing = grant_vld[a] ? grant_cr[a] : 4'd0;
          r.out_granted = grant_vld[a]; r.out_last = (a == NumAgents - 1);
          add_result(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver.
  int send_gap = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_item(in_data_i);
        void'(pending_items.pop_front());
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (send_gap > 0 || pending_items.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
      end
    end
  end

  // Long receiver hold, counted on its own.
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (hold_off && hold_cnt < 400) hold_cnt <= hold_cnt + 1;
  end

  // Monitor and checker.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_data_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_data_o !== e) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, e, out_data_o);
            errors++;
          end
        end
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (hold_off && hold_cnt < 400) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0; cfg_idx_i <= CFG_NONE;
    case (idx)
      CFG_GAIN: gain_q = val[11:0];
      CFG_FACTOR: factor_q = val[8:0];
      CFG_INIT: begin
        init_q = val[7:0]; reload_windows();
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t mk(func_e f, int ag, int cr);
    in_item_t t;
    t = '0;
    t.func = f; t.agent_id = ag[4:0]; t.crossing_id = cr[3:0];
    return t;
  endfunction

  function automatic in_item_t rand_obs(int cr);
    in_item_t t;
    t = mk(FUNC_OBSERVE, 0, cr);
    t.agent_id = 5'($urandom); t.wait_age = 16'($urandom);
    t.obs_capacity = 8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 12));
    t.obs_occupied = 8'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 6));
    t.obs_stalled = ($urandom_range(0, 3) == 0);
    t.obs_delayed = 1'($urandom); t.obs_info_congested = ($urandom_range(0, 5) == 0);
    return t;
  endfunction

  // One round: observations, requests with ages, acks/queries and unused function codes, then end of round.
  task automatic queue_round(int n);
    in_item_t t;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          t = mk(FUNC_REQUEST, $urandom_range(0, 31), $urandom_range(0, 3));
          t.wait_age = 16'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 3));
          t.obs_capacity = 8'($urandom); t.obs_occupied = 8'($urandom);
        end
        4: t = rand_obs($urandom_range(0, 15));
        5, 6: t = mk(FUNC_ACK, $urandom_range(0, 31), $urandom_range(0, 3));
        7: t = mk(FUNC_QUERY, $urandom_range(0, 31), $urandom_range(0, 15));
        8: begin
          t = '0; t.func = 3'($urandom_range(5, 7));
          t.agent_id = 5'($urandom); t.wait_age = 16'($urandom);
        end
        default: t = mk(func_e'($urandom_range(0, 3)), $urandom, $urandom);
      endcase
      add_item(t);
    end
    add_item(mk(FUNC_END, 0, 0));
  endtask

  initial begin
    in_item_t t;
    predict_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(CFG_GAIN, 4095);
    write_reg(CFG_FACTOR, 256);
    write_reg(CFG_INIT, 255);

    t = mk(FUNC_OBSERVE, 31, 15);
    t.obs_capacity = 8'hFF; t.obs_stalled = 1'b1; t.obs_delayed = 1'b1;
    t.obs_info_congested = 1'b0;
    add_item(t);
    add_item(rand_obs(0));
    t = mk(FUNC_REQUEST, 0, 0); t.wait_age = 16'hFFFF; add_item(t);
    t = mk(FUNC_REQUEST, 31, 15); t.wait_age = '0; add_item(t);
    t = mk(FUNC_REQUEST, 5, 0); t.wait_age = 16'hFFFF; add_item(t);
    t = mk(FUNC_REQUEST, 5, 1); t.wait_age = 16'd7; add_item(t);
    t = '0; t.func = 3'd7; t = ~t; t.func = 3'd7; add_item(t);
    add_item(mk(FUNC_END, 0, 0));
    add_item(mk(FUNC_QUERY, 0, 0));
    add_item(mk(FUNC_ACK, 0, 0));
    add_item(mk(FUNC_ACK, 0, 0));
    add_item(mk(FUNC_ACK, 31, 14));
    add_item(mk(FUNC_QUERY, 31, 15));
    t = mk(FUNC_REQUEST, 31, 15); add_item(t);
    add_item(mk(FUNC_END, 0, 0));
    wait_drained();

    write_reg(CFG_GAIN, 1);
    write_reg(CFG_FACTOR, 1);
    write_reg(CFG_INIT, 0);
    for (int r = 0; r < 4; r++) queue_round(15);
    hold_off = 1;
    wait_drained();

    write_reg(CFG_GAIN, 256);
    write_reg(CFG_FACTOR, 300);
    write_reg(CFG_INIT, 3);
    for (int r = 0; r < 6; r++) queue_round(15);
    wait_drained();

    write_reg(CFG_GAIN, $urandom_range(1, 4095));
    write_reg(CFG_FACTOR, $urandom_range(1, 256));
    write_reg(CFG_INIT, $urandom_range(1, 255));
    for (int r = 0; r < 8; r++) queue_round(15);
    wait_drained();

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > 2000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/aac_pkg.sv
rtl/core/aimd_admission_controller_core.sv
verif/tb_top.sv
